FILE: rtl/pva_pkg.sv
// Shared widths, request and action codes, and the beat types of the voice allocator.
package pva_pkg;

	localparam int REQ_W   = 2;
	localparam int NOTE_W  = 7;
	localparam int VOICE_W = 3;
	localparam int AGE_W   = 32;

	localparam logic [REQ_W-1:0] REQ_ON  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_OFF = 2'd1;
	localparam logic [REQ_W-1:0] REQ_ALL = 2'd2;

	localparam logic ACT_START   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// Token that walks down the row of voice cells, one cell per cycle while the row advances.
	typedef struct packed {
		logic              valid;
		logic [REQ_W-1:0]  req;
		logic [NOTE_W-1:0] note;
		logic              found;
		logic [AGE_W-1:0]  best_age;
		logic [NOTE_W-1:0] best_note;
	} tok_t;

	// Start write broadcast to the row; the target index travels beside it.
	typedef struct packed {
		logic              valid;
		logic [NOTE_W-1:0] note;
		logic [AGE_W-1:0]  age;
	} wr_t;

	typedef struct packed {
		logic               action;
		logic [VOICE_W-1:0] voice;
		logic [NOTE_W-1:0]  note;
		logic               last;
	} res_t;

endpackage

FILE: rtl/pva_req_if.sv
// Request channel: note event beats into the allocator.
interface pva_req_if;
	import pva_pkg::*;

	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [NOTE_W-1:0] note;

	modport source(output valid, output req_type, output note, input ready);
	modport sink(input valid, input req_type, input note, output ready);
endinterface

FILE: rtl/pva_res_if.sv
// Result channel: voice start and release beats out of the allocator.
interface pva_res_if;
	import pva_pkg::*;

	logic               valid;
	logic               ready;
	logic               action;
	logic [VOICE_W-1:0] voice;
	logic [NOTE_W-1:0]  note_res;
	logic               last;

	modport source(output valid, output action, output voice, output note_res, output last,
		input ready);
	modport sink(input valid, input action, input voice, input note_res, input last,
		output ready);
endinterface

FILE: rtl/polyphonic_voice_allocator_unit.sv
// Top level: voice allocator with oldest-voice stealing, built as a row of voice cells.
// Usage:
//   req (sink): one beat per note event: req_type 0 note on, 1 note off, 2 all off;
//     req_type 3 is accepted and dropped.
//   res (source): start and release beats, last set on the final beat of an event.
//   A request launches a token into cell 0; it advances one cell per cycle while res is
//   not stalled, each matching cell reporting a release as the token passes. Note on
//   needs the whole row before the voice is known; a steal adds a separate start beat
//   after the release of the stolen voice. Note off and all off emit releases in voice
//   order as the token passes, the last beat registered when the token leaves the row.
//   One event is in flight at a time, its pace set by the walk of the token through
//   the row. A new request is taken as soon as the previous one has handed off its
//   final beat to the output register.
//   Reset frees every voice, clears notes, age stamps and the age clock.
//   When res is stalled the whole row holds; nothing is dropped.
module polyphonic_voice_allocator_unit #(
	parameter int VOICES = 8
) (
	input  logic   clk,
	input  logic   arst_n,
	pva_req_if.sink   req,
	pva_res_if.source res
);
	import pva_pkg::*;

	localparam int VW = $clog2(VOICES);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0] st_q;
	logic [1:0] st_nxt;

	tok_t          tok   [VOICES+1];
	logic [VW-1:0] fidx  [VOICES+1];
	logic [VW-1:0] bidx  [VOICES+1];
	logic [VW-1:0] evv   [VOICES];
	logic [NOTE_W-1:0] evn [VOICES];
	logic [VOICES-1:0] ev_vld;

	tok_t          inj_q;
	wr_t           wr;
	logic [VW-1:0] wr_idx;
	logic [AGE_W-1:0] age_q;

	res_t out_q, out_nxt, pend_q, pend_nxt;
	logic out_vld_q, pend_vld_q;
	logic ld_out, ld_pend, clr_pend, wr_go;

	logic              adv, acc, ex, ev_any;
	logic [VW-1:0]     ev_voice;
	logic [NOTE_W-1:0] ev_note;
	tok_t              tok_x;
	logic [VW-1:0]     chosen;

	// the row advances unless a finished beat is waiting on a stalled receiver
	assign adv       = !out_vld_q || res.ready;
	assign req.ready = (st_q == ST_IDLE);
	assign acc       = req.valid && req.ready;

	assign tok[0]  = inj_q;
	assign fidx[0] = '0;
	assign bidx[0] = '0;

	for (genvar k = 0; k < VOICES; k++) begin : g_cell
		pva_cell #(.VOICES(VOICES), .IDX(k)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.tok_i   (tok[k]),
			.free_i  (fidx[k]),
			.best_i  (bidx[k]),
			.wr      (wr),
			.wr_idx  (wr_idx),
			.tok_o   (tok[k+1]),
			.free_o  (fidx[k+1]),
			.best_o  (bidx[k+1]),
			.ev_vld  (ev_vld[k]),
			.ev_voice(evv[k]),
			.ev_note (evn[k])
		);
	end

	// at most one cell holds the token, so the cell outputs combine by OR
	always_comb begin
		ev_voice = '0;
		ev_note  = '0;
		for (int k = 0; k < VOICES; k++) begin
			ev_voice = ev_voice | evv[k];
			ev_note  = ev_note | evn[k];
		end
	end
	assign ev_any = |ev_vld;

	assign tok_x  = tok[VOICES];
	assign ex     = tok_x.valid;
	assign chosen = tok_x.found ? fidx[VOICES] : bidx[VOICES];

	assign wr.valid = wr_go;
	assign wr.note  = tok_x.note;
	assign wr.age   = age_q + AGE_W'(1);
	assign wr_idx   = chosen;

	always_comb begin
		st_nxt   = st_q;
		ld_out   = 1'b0;
		ld_pend  = 1'b0;
		clr_pend = 1'b0;
		wr_go    = 1'b0;
		out_nxt  = '0;
		pend_nxt = '0;
		if (adv) begin
			priority if (ev_any) begin
				// hold each release until the next one shows whether it is the final beat
				if (pend_vld_q) begin
					ld_out       = 1'b1;
					out_nxt      = pend_q;
					out_nxt.last = 1'b0;
				end
				ld_pend  = 1'b1;
				pend_nxt = '{action: ACT_RELEASE, voice: VOICE_W'(ev_voice),
					note: ev_note, last: 1'b0};
			end else if (ex) begin
				st_nxt = ST_IDLE;
				if (tok_x.req == REQ_ON) begin
					wr_go  = 1'b1;
					ld_out = 1'b1;
					if (tok_x.found) begin
						out_nxt = '{action: ACT_START, voice: VOICE_W'(chosen),
							note: tok_x.note, last: 1'b1};
					end else begin
						out_nxt  = '{action: ACT_RELEASE, voice: VOICE_W'(chosen),
							note: tok_x.best_note, last: 1'b0};
						ld_pend  = 1'b1;
						pend_nxt = '{action: ACT_START, voice: VOICE_W'(chosen),
							note: tok_x.note, last: 1'b1};
						st_nxt   = ST_FLUSH;
					end
				end else if (pend_vld_q) begin
					ld_out       = 1'b1;
					out_nxt      = pend_q;
					out_nxt.last = 1'b1;
					clr_pend     = 1'b1;
				end
			end else if (st_q == ST_FLUSH) begin
				ld_out       = 1'b1;
				out_nxt      = pend_q;
				out_nxt.last = 1'b1;
				clr_pend     = 1'b1;
				st_nxt       = ST_IDLE;
			end else begin
				// hold: no token reports and nothing is left to flush
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			inj_q      <= '0;
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
			age_q      <= '0;
		end else begin
			if (acc) begin
				if (req.req_type == REQ_ON || req.req_type == REQ_OFF ||
						req.req_type == REQ_ALL) begin
					inj_q.valid     <= 1'b1;
					inj_q.req       <= req.req_type;
					inj_q.note      <= req.note;
					inj_q.found     <= 1'b0;
					inj_q.best_age  <= '1;
					inj_q.best_note <= '0;
					st_q            <= ST_SCAN;
				end
			end else begin
				if (adv) begin
					inj_q.valid <= 1'b0;
				end
				st_q <= st_nxt;
			end
			if (ld_out) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
			if (ld_pend) begin
				pend_vld_q <= 1'b1;
			end else if (clr_pend) begin
				pend_vld_q <= 1'b0;
			end
			if (wr_go) begin
				age_q <= age_q + AGE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_q <= out_nxt;
		end
		if (ld_pend) begin
			pend_q <= pend_nxt;
		end
	end

	assign res.valid    = out_vld_q;
	assign res.action   = out_q.action;
	assign res.voice    = out_q.voice;
	assign res.note_res = out_q.note;
	assign res.last     = out_q.last;

`ifndef NO_ASSERTIONS
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(ev_vld))
		else $error("more than one voice cell reports at once");

	a_exit_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		!(ex && ev_any))
		else $error("token leaves the row while a cell still reports");

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !pend_vld_q)
		else $error("request taken while a result is still pending");

	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FLUSH) |-> pend_vld_q)
		else $error("flush state without a pending start beat");

	a_start_advances_clock: assert property (@(posedge clk) disable iff (!arst_n)
		wr_go |=> (age_q == $past(age_q) + AGE_W'(1)))
		else $error("age clock did not advance on a voice start");
`endif

endmodule

FILE: rtl/pva_cell.sv
// One voice cell: holds busy, note and age stamp, and processes the passing token.
module pva_cell #(
	parameter int VOICES = 8,
	parameter int IDX    = 0
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  pva_pkg::tok_t              tok_i,
	input  logic [$clog2(VOICES)-1:0]  free_i,
	input  logic [$clog2(VOICES)-1:0]  best_i,
	input  pva_pkg::wr_t               wr,
	input  logic [$clog2(VOICES)-1:0]  wr_idx,
	output pva_pkg::tok_t              tok_o,
	output logic [$clog2(VOICES)-1:0]  free_o,
	output logic [$clog2(VOICES)-1:0]  best_o,
	output logic                       ev_vld,
	output logic [$clog2(VOICES)-1:0]  ev_voice,
	output logic [pva_pkg::NOTE_W-1:0] ev_note
);
	import pva_pkg::*;

	localparam int VW = $clog2(VOICES);
	localparam logic [VW-1:0] MY_IDX = VW'(IDX);

	logic              busy_q;
	logic [NOTE_W-1:0] note_q;
	logic [AGE_W-1:0]  age_q;

	tok_t          tok_nxt;
	logic [VW-1:0] free_nxt;
	logic [VW-1:0] best_nxt;
	logic          hit;

	always_comb begin
		tok_nxt  = tok_i;
		free_nxt = free_i;
		best_nxt = best_i;
		hit      = 1'b0;
		if (tok_i.valid) begin
			unique case (tok_i.req)
				REQ_ON: begin
					// first free voice wins; before it, track the oldest busy one
					// (cell 0, when busy, always seeds the candidate so its note travels along)
					if (!tok_i.found) begin
						if (!busy_q) begin
							tok_nxt.found = 1'b1;
							free_nxt      = MY_IDX;
						end else if (age_q < tok_i.best_age || IDX == 0) begin
							tok_nxt.best_age  = age_q;
							tok_nxt.best_note = note_q;
							best_nxt          = MY_IDX;
						end
					end
				end
				REQ_OFF: hit = busy_q && (note_q == tok_i.note);
				REQ_ALL: hit = 1'b1;
				default: ;
			endcase
		end
	end

	assign ev_vld   = hit;
	assign ev_voice = hit ? MY_IDX : '0;
	assign ev_note  = (hit && busy_q) ? note_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_o  <= '0;
			free_o <= '0;
			best_o <= '0;
		end else if (adv) begin
			tok_o  <= tok_nxt;
			free_o <= free_nxt;
			best_o <= best_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			note_q <= '0;
			age_q  <= '0;
		end else if (adv && hit) begin
			busy_q <= 1'b0;
			note_q <= '0;
		end else if (wr.valid && (wr_idx == MY_IDX)) begin
			busy_q <= 1'b1;
			note_q <= wr.note;
			age_q  <= wr.age;
		end
	end

endmodule
